// ----- rtl/tbac_pkg.sv -----
// Shared types and constants for the twelve-bit accumulator CPU.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tbac_pkg;

  // Word, address and floating accumulator widths.
  localparam int unsigned WordW  = 12;
  localparam int unsigned MemWords = 4096;
  localparam int unsigned AddrW  = $clog2(MemWords);
  localparam int unsigned FpW    = 32;

  // Request codes on the cmd port.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  // Major opcodes in instruction bits 11..9.
  localparam logic [2:0] OP_AND = 3'd0;
  localparam logic [2:0] OP_TAD = 3'd1;
  localparam logic [2:0] OP_ISZ = 3'd2;
  localparam logic [2:0] OP_DCA = 3'd3;
  localparam logic [2:0] OP_JMS = 3'd4;
  localparam logic [2:0] OP_JMP = 3'd5;
  localparam logic [2:0] OP_IOT = 3'd6;
  localparam logic [2:0] OP_OPR = 3'd7;

  // Floating-point IOT codes.
  localparam logic [WordW-1:0] IOT_FCLR = 12'o6550;
  localparam logic [WordW-1:0] IOT_FLD  = 12'o6551;
  localparam logic [WordW-1:0] IOT_FST  = 12'o6552;
  localparam logic [WordW-1:0] IOT_FADD = 12'o6553;
  localparam logic [WordW-1:0] IOT_FMUL = 12'o6554;

  // Group 1 rotate field codes.
  localparam logic [2:0] ROT_NONE = 3'd0;
  localparam logic [2:0] ROT_BSW  = 3'd1;
  localparam logic [2:0] ROT_RAL  = 3'd2;
  localparam logic [2:0] ROT_RTL  = 3'd3;
  localparam logic [2:0] ROT_RAR  = 3'd4;
  localparam logic [2:0] ROT_RTR  = 3'd5;
  localparam logic [2:0] ROT_BAD6 = 3'd6;
  localparam logic [2:0] ROT_BAD7 = 3'd7;

  localparam logic [WordW-1:0] PC_RESET = 12'o0200;
  localparam logic [7:0]       EXP_BIAS = 8'd127;

  // Controller states.
  typedef enum logic [5:0] {
    S_IDLE, S_WR, S_RD, S_RDCAP, S_START, S_FISSUE, S_FETCH, S_DECODE,
    S_IND, S_EA, S_OPX, S_PTR, S_FPMA, S_FR0, S_FR1, S_FR2, S_FLOAD,
    S_FS0, S_FS1, S_FS2, S_FA_ALIGN, S_FA_SUM, S_FA_NORM, S_FM_MUL,
    S_FM_PACK, S_DONE
  } state_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [5:0] {
    U_NOP, U_LATCH, U_MWRITE, U_RDISSUE, U_RDCAP, U_START, U_FISSUE,
    U_FETCH, U_INDISSUE, U_IND, U_OPISSUE, U_AND, U_TAD, U_ISZ, U_DCA,
    U_JMS, U_JMP, U_OPR, U_FCLR, U_UNSUP, U_PTRISSUE, U_PTR, U_FPMA,
    U_FR0, U_FR1, U_FR2, U_FLOAD, U_FS0, U_FS1, U_FS2, U_FA_ALIGN,
    U_FA_SUM, U_FA_NORM, U_FA_PACK, U_FM_MUL, U_FM_PACK
  } uop_e;

  // Command from controller to datapath.
  typedef struct packed {
    uop_e uop;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [WordW-1:0] ir;
    logic             halted;
    logic             norm_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/twelve_bit_accumulator_cpu_unit.sv -----
// Top level of the twelve-bit accumulator CPU.
// Instantiates tbac_ctrl and tbac_dp; depends on tbac_pkg.
//
// Usage: drive cmd_i, address_i and data_i with start high; the request is
// taken at a clock edge where busy is low. busy then stays high until the
// result has been shown. The result is on the output ports for exactly one
// cycle, marked by done_o; the receiver cannot stall it and must take it.
// Each word fetched or stored goes through the single memory port in turn;
// indirect addressing adds a pointer read, and an execute while halted
// goes straight to done_o. Floating add normalizes left one bit at a time
// (up to 23 bits). A new request is taken the cycle after done_o. The user
// must write the switch register with cfg_we_i only while idle; the block
// itself does not enforce it.
// Reset sets the program counter to 0200 octal and clears accumulator,
// link, floating accumulator, halt flag and switch register; memory content
// is undefined until written.
`default_nettype none

module twelve_bit_accumulator_cpu_unit
  import tbac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [AddrW-1:0] address_i,
  input  wire logic [WordW-1:0] data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [WordW-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic [WordW-1:0]      read_data_o,
  output logic [AddrW-1:0]      program_counter_o,
  output logic [WordW-1:0]      accumulator_o,
  output logic                  link_bit_o,
  output logic [FpW-1:0]        float_accumulator_o,
  output logic                  halted_o,
  output logic                  unsupported_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer.
  tbac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .done_o (done_o)
  );

  // Registers, memory and arithmetic.
  tbac_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .address_i           (address_i),
    .data_i              (data_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .read_data_o         (read_data_o),
    .program_counter_o   (program_counter_o),
    .accumulator_o       (accumulator_o),
    .link_bit_o          (link_bit_o),
    .float_accumulator_o (float_accumulator_o),
    .halted_o            (halted_o),
    .unsupported_o       (unsupported_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tbac_dp.sv -----
// Datapath of the twelve-bit accumulator CPU: memory, registers, operate
// logic and the floating-point unit. Depends on tbac_pkg.
`default_nettype none

module tbac_dp
  import tbac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  output dp_stat_t              stat_o,
  input  wire logic [AddrW-1:0] address_i,
  input  wire logic [WordW-1:0] data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [WordW-1:0] cfg_wdata_i,
  output logic [WordW-1:0]      read_data_o,
  output logic [AddrW-1:0]      program_counter_o,
  output logic [WordW-1:0]      accumulator_o,
  output logic                  link_bit_o,
  output logic [FpW-1:0]        float_accumulator_o,
  output logic                  halted_o,
  output logic                  unsupported_o
);

  // Main memory, single port with registered read data.
  logic [WordW-1:0] mem [MemWords];
  logic [AddrW-1:0] mem_addr;
  logic             mem_we;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata_q;

  // Architectural and control registers.
  logic [AddrW-1:0] pc_q;
  logic [WordW-1:0] ac_q, sw_q, rdo_q;
  logic             link_q, halt_q, unsup_q;
  logic [FpW-1:0]   fpa_q;

  // Payload registers.
  logic [AddrW-1:0] addr_q, ma_q;
  logic [WordW-1:0] data_q, ir_q, w1_q;
  logic [7:0]       w0_q, e_q;
  logic [FpW-1:0]   opb_q;
  logic [23:0]      fa_q, fb_q;
  logic             sa_q, sb_q, neg_q;
  logic [24:0]      t_q;
  logic [47:0]      prod_q;

  logic [WordW-1:0] rd_inc;
  logic             autoinc;
  assign rd_inc  = mem_rdata_q + 12'd1;
  assign autoinc = (ma_q[AddrW-1:3] == 9'd1);

  // Memory port selection.
  always_comb begin
    mem_addr  = ma_q;
    mem_we    = 1'b0;
    mem_wdata = rd_inc;
    case (cmd_i.uop)
      U_MWRITE: begin
        mem_addr  = addr_q;
        mem_we    = 1'b1;
        mem_wdata = data_q;
      end
      U_RDISSUE:  mem_addr = addr_q;
      U_FISSUE:   mem_addr = pc_q;
      U_PTRISSUE: mem_addr = pc_q;
      U_IND:      mem_we   = autoinc;
      U_ISZ:      mem_we   = 1'b1;
      U_DCA: begin
        mem_we    = 1'b1;
        mem_wdata = ac_q;
      end
      U_JMS: begin
        mem_we    = 1'b1;
        mem_wdata = pc_q;
      end
      U_PTR, U_FPMA: mem_addr = mem_rdata_q;
      U_FR0: mem_addr = ma_q + 12'd1;
      U_FR1: mem_addr = ma_q + 12'd2;
      U_FS0: begin
        mem_we    = 1'b1;
        mem_wdata = {4'd0, fpa_q[30:23]};
      end
      U_FS1: begin
        mem_addr  = ma_q + 12'd1;
        mem_we    = 1'b1;
        mem_wdata = {fpa_q[31], fpa_q[22:12]};
      end
      U_FS2: begin
        mem_addr  = ma_q + 12'd2;
        mem_we    = 1'b1;
        mem_wdata = fpa_q[11:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // Operate microinstructions, both groups.
  logic [WordW-1:0] g_ac;
  logic [AddrW-1:0] g_pc;
  logic             g_link, g_halt, g_unsup, g_skip;
  logic [12:0]      g_v;
  always_comb begin
    g_ac    = ac_q;
    g_link  = link_q;
    g_pc    = pc_q;
    g_halt  = halt_q;
    g_unsup = 1'b0;
    g_skip  = 1'b0;
    g_v     = {link_q, ac_q};
    if (ir_q[8]) begin
      if (ir_q[0]) begin
        g_unsup = 1'b1;
      end else begin
        if (ir_q[3]) begin
          g_skip = 1'b1;
          if (ir_q[4] && link_q) g_skip = 1'b0;
          if (ir_q[5] && (ac_q == '0)) g_skip = 1'b0;
          if (ir_q[6] && ac_q[11]) g_skip = 1'b0;
        end else begin
          if (ir_q[4] && link_q) g_skip = 1'b1;
          if (ir_q[5] && (ac_q == '0)) g_skip = 1'b1;
          if (ir_q[6] && ac_q[11]) g_skip = 1'b1;
        end
        if (g_skip) g_pc = pc_q + 12'd1;
        if (ir_q[7]) g_ac = '0;
        if (ir_q[2]) g_ac = g_ac | sw_q;
        if (ir_q[1]) g_halt = 1'b1;
      end
    end else begin
      if (ir_q[7]) g_ac = '0;
      if (ir_q[6]) g_link = 1'b0;
      if (ir_q[5]) g_ac = ~g_ac;
      if (ir_q[4]) g_link = ~g_link;
      g_v = {g_link, g_ac};
      if (ir_q[0]) g_v = g_v + 13'd1;
      case (ir_q[3:1])
        ROT_BSW: g_v = {g_v[12], g_v[5:0], g_v[11:6]};
        ROT_RAL: g_v = {g_v[11:0], g_v[12]};
        ROT_RTL: g_v = {g_v[10:0], g_v[12:11]};
        ROT_RAR: g_v = {g_v[0], g_v[12:1]};
        ROT_RTR: g_v = {g_v[1:0], g_v[12:2]};
        ROT_BAD6, ROT_BAD7: g_unsup = 1'b1;
        default: ;
      endcase
      g_link = g_v[12];
      g_ac   = g_v[11:0];
    end
  end

  // Floating add alignment: larger exponent operand goes first.
  logic        fa_swap;
  logic [7:0]  big_e, sm_e, fa_d;
  logic [23:0] big_f, sm_f;
  logic        big_s, sm_s;
  logic [25:0] sum_a, sum_b, sum_v;
  always_comb begin
    fa_swap = (fpa_q[30:23] < opb_q[30:23]);
    if (fa_swap) begin
      big_e = opb_q[30:23];
      big_s = opb_q[31];
      big_f = {1'b1, opb_q[22:0]};
      sm_e  = fpa_q[30:23];
      sm_s  = fpa_q[31];
      sm_f  = {1'b1, fpa_q[22:0]};
    end else begin
      big_e = fpa_q[30:23];
      big_s = fpa_q[31];
      big_f = {1'b1, fpa_q[22:0]};
      sm_e  = opb_q[30:23];
      sm_s  = opb_q[31];
      sm_f  = {1'b1, opb_q[22:0]};
    end
    fa_d  = big_e - sm_e;
    sum_a = sa_q ? -{2'b00, fa_q} : {2'b00, fa_q};
    sum_b = sb_q ? -{2'b00, fb_q} : {2'b00, fb_q};
    sum_v = sum_a + sum_b;
  end

  assign stat_o.ir        = ir_q;
  assign stat_o.halted    = halt_q;
  assign stat_o.norm_done = t_q[24] | t_q[23] | (t_q == '0);

  // Architectural and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PC_RESET;
      ac_q    <= '0;
      link_q  <= 1'b0;
      fpa_q   <= '0;
      halt_q  <= 1'b0;
      unsup_q <= 1'b0;
      rdo_q   <= '0;
      sw_q    <= '0;
    end else begin
      if (cfg_we_i) sw_q <= cfg_wdata_i;
      case (cmd_i.uop)
        U_LATCH: begin
          rdo_q   <= '0;
          unsup_q <= 1'b0;
        end
        U_RDCAP: rdo_q <= mem_rdata_q;
        U_START: begin
          pc_q   <= addr_q;
          halt_q <= 1'b0;
        end
        U_FETCH, U_PTRISSUE: pc_q <= pc_q + 12'd1;
        U_AND: ac_q <= ac_q & mem_rdata_q;
        U_TAD: begin
          {link_q, ac_q} <= {link_q, ac_q} + {1'b0, mem_rdata_q};
        end
        U_ISZ: if (rd_inc == '0) pc_q <= pc_q + 12'd1;
        U_DCA: ac_q <= '0;
        U_JMS: pc_q <= ma_q + 12'd1;
        U_JMP: pc_q <= ma_q;
        U_OPR: begin
          ac_q    <= g_ac;
          link_q  <= g_link;
          pc_q    <= g_pc;
          halt_q  <= g_halt;
          unsup_q <= g_unsup;
        end
        U_FCLR:  fpa_q <= '0;
        U_UNSUP: unsup_q <= 1'b1;
        U_FLOAD: fpa_q <= opb_q;
        U_FA_PACK: begin
          if (t_q[24]) begin
            fpa_q <= {neg_q, e_q + 8'd1, t_q[23:1]};
          end else begin
            fpa_q <= {neg_q, e_q, t_q[22:0]};
          end
        end
        U_FM_PACK: begin
          if (prod_q[47]) begin
            fpa_q <= {neg_q, e_q + 8'd1, prod_q[46:24]};
          end else begin
            fpa_q <= {neg_q, e_q, prod_q[45:23]};
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.uop)
      U_LATCH: begin
        addr_q <= address_i;
        data_q <= data_i;
      end
      U_FETCH: begin
        ir_q <= mem_rdata_q;
        ma_q <= {(mem_rdata_q[7] ? pc_q[11:7] : 5'd0), mem_rdata_q[6:0]};
      end
      U_IND:  ma_q <= autoinc ? rd_inc : mem_rdata_q;
      U_FPMA: ma_q <= mem_rdata_q;
      U_FR0:  w0_q <= mem_rdata_q[7:0];
      U_FR1:  w1_q <= mem_rdata_q;
      U_FR2:  opb_q <= {w1_q[11], w0_q, w1_q[10:0], mem_rdata_q};
      U_FA_ALIGN: begin
        fa_q <= big_f;
        fb_q <= (fa_d >= 8'd24) ? 24'd0 : (sm_f >> fa_d[4:0]);
        sa_q <= big_s;
        sb_q <= sm_s;
        e_q  <= big_e;
      end
      U_FA_SUM: begin
        neg_q <= sum_v[25];
        t_q   <= sum_v[25] ? 25'(-sum_v) : sum_v[24:0];
      end
      U_FA_NORM: begin
        t_q <= {t_q[23:0], 1'b0};
        e_q <= e_q - 8'd1;
      end
      U_FM_MUL: begin
        prod_q <= 48'({1'b1, fpa_q[22:0]}) * 48'({1'b1, opb_q[22:0]});
        e_q    <= fpa_q[30:23] + opb_q[30:23] - EXP_BIAS;
        neg_q  <= fpa_q[31] ^ opb_q[31];
      end
      default: ;
    endcase
  end

  assign read_data_o         = rdo_q;
  assign program_counter_o   = pc_q;
  assign accumulator_o       = ac_q;
  assign link_bit_o          = link_q;
  assign float_accumulator_o = fpa_q;
  assign halted_o            = halt_q;
  assign unsupported_o       = unsup_q;

endmodule

`default_nettype wire

// ----- rtl/tbac_ctrl.sv -----
// Controller state machine of the twelve-bit accumulator CPU: sequences
// each request into datapath micro-operations. Depends on tbac_pkg.
`default_nettype none

module tbac_ctrl
  import tbac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] cmd_i,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o,
  output logic            done_o
);

  state_e state_q, state_d;
  logic [2:0] opc;
  assign opc = stat_i.ir[11:9];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and micro-operation.
  always_comb begin
    state_d   = state_q;
    cmd_o.uop = U_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.uop = U_LATCH;
          unique case (cmd_i)
            CMD_WRITE: state_d = S_WR;
            CMD_READ:  state_d = S_RD;
            CMD_START: state_d = S_START;
            default:   state_d = stat_i.halted ? S_DONE : S_FISSUE;
          endcase
        end
      end
      S_WR: begin
        cmd_o.uop = U_MWRITE;
        state_d   = S_DONE;
      end
      S_RD: begin
        cmd_o.uop = U_RDISSUE;
        state_d   = S_RDCAP;
      end
      S_RDCAP: begin
        cmd_o.uop = U_RDCAP;
        state_d   = S_DONE;
      end
      S_START: begin
        cmd_o.uop = U_START;
        state_d   = S_DONE;
      end
      S_FISSUE: begin
        cmd_o.uop = U_FISSUE;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.uop = U_FETCH;
        state_d   = S_DECODE;
      end
      S_DECODE: begin
        if (opc == OP_OPR) begin
          cmd_o.uop = U_OPR;
          state_d   = S_DONE;
        end else if (opc == OP_IOT) begin
          if (stat_i.ir == IOT_FCLR) begin
            cmd_o.uop = U_FCLR;
            state_d   = S_DONE;
          end else if (stat_i.ir == IOT_FLD || stat_i.ir == IOT_FST ||
                       stat_i.ir == IOT_FADD || stat_i.ir == IOT_FMUL) begin
            cmd_o.uop = U_PTRISSUE;
            state_d   = S_PTR;
          end else begin
            cmd_o.uop = U_UNSUP;
            state_d   = S_DONE;
          end
        end else if (stat_i.ir[8]) begin
          cmd_o.uop = U_INDISSUE;
          state_d   = S_IND;
        end else begin
          state_d = S_EA;
        end
      end
      S_IND: begin
        cmd_o.uop = U_IND;
        state_d   = S_EA;
      end
      // Effective address is final here.
      S_EA: begin
        case (opc)
          OP_AND, OP_TAD, OP_ISZ: begin
            cmd_o.uop = U_OPISSUE;
            state_d   = S_OPX;
          end
          OP_DCA: begin
            cmd_o.uop = U_DCA;
            state_d   = S_DONE;
          end
          OP_JMS: begin
            cmd_o.uop = U_JMS;
            state_d   = S_DONE;
          end
          default: begin
            cmd_o.uop = U_JMP;
            state_d   = S_DONE;
          end
        endcase
      end
      S_OPX: begin
        case (opc)
          OP_AND:  cmd_o.uop = U_AND;
          OP_TAD:  cmd_o.uop = U_TAD;
          default: cmd_o.uop = U_ISZ;
        endcase
        state_d = S_DONE;
      end
      S_PTR: begin
        cmd_o.uop = U_PTR;
        state_d   = S_FPMA;
      end
      S_FPMA: begin
        cmd_o.uop = U_FPMA;
        state_d   = (stat_i.ir == IOT_FST) ? S_FS0 : S_FR0;
      end
      S_FR0: begin
        cmd_o.uop = U_FR0;
        state_d   = S_FR1;
      end
      S_FR1: begin
        cmd_o.uop = U_FR1;
        state_d   = S_FR2;
      end
      S_FR2: begin
        cmd_o.uop = U_FR2;
        if (stat_i.ir == IOT_FLD) begin
          state_d = S_FLOAD;
        end else if (stat_i.ir == IOT_FADD) begin
          state_d = S_FA_ALIGN;
        end else begin
          state_d = S_FM_MUL;
        end
      end
      S_FLOAD: begin
        cmd_o.uop = U_FLOAD;
        state_d   = S_DONE;
      end
      S_FS0: begin
        cmd_o.uop = U_FS0;
        state_d   = S_FS1;
      end
      S_FS1: begin
        cmd_o.uop = U_FS1;
        state_d   = S_FS2;
      end
      S_FS2: begin
        cmd_o.uop = U_FS2;
        state_d   = S_DONE;
      end
      S_FA_ALIGN: begin
        cmd_o.uop = U_FA_ALIGN;
        state_d   = S_FA_SUM;
      end
      S_FA_SUM: begin
        cmd_o.uop = U_FA_SUM;
        state_d   = S_FA_NORM;
      end
      // One bit of left normalization per cycle.
      S_FA_NORM: begin
        if (stat_i.norm_done) begin
          cmd_o.uop = U_FA_PACK;
          state_d   = S_DONE;
        end else begin
          cmd_o.uop = U_FA_NORM;
        end
      end
      S_FM_MUL: begin
        cmd_o.uop = U_FM_MUL;
        state_d   = S_FM_PACK;
      end
      S_FM_PACK: begin
        cmd_o.uop = U_FM_PACK;
        state_d   = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // A finished request always returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("no return to idle after result");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  // Fetch is always followed by decode.
  a_fetch_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_DECODE))
    else $error("fetch not followed by decode");

endmodule

`default_nettype wire

// ----- tb/sv/tb_twelve_bit_accumulator_cpu_unit.sv -----
// Self-checking testbench for the twelve-bit accumulator CPU unit.
// Depends on tbac_pkg and twelve_bit_accumulator_cpu_unit. A built-in predictor
// mirrors the CPU and checks every result against what it expects.
`default_nettype none

module tb_twelve_bit_accumulator_cpu_unit
  import tbac_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReported = 10;

  // One result word set as the block shows it.
  typedef struct packed {
    logic [WordW-1:0] rdata;
    logic [AddrW-1:0] pc;
    logic [WordW-1:0] acc;
    logic             lnk;
    logic [FpW-1:0]   fac;
    logic             hlt;
    logic             unsup;
  } cpu_view_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       cmd_i;
  logic [AddrW-1:0] address_i;
  logic [WordW-1:0] data_i;
  logic             cfg_we_i;
  logic [WordW-1:0] cfg_wdata_i;
  logic             done_o;
  logic [WordW-1:0] read_data_o;
  logic [AddrW-1:0] program_counter_o;
  logic [WordW-1:0] accumulator_o;
  logic             link_bit_o;
  logic [FpW-1:0]   float_accumulator_o;
  logic             halted_o;
  logic             unsupported_o;

  // Predicted machine state.
  logic [WordW-1:0] mem_image [MemWords];
  logic [AddrW-1:0] cpu_pc;
  logic [WordW-1:0] cpu_acc;
  logic             cpu_lnk;
  logic [FpW-1:0]   cpu_fac;
  logic             cpu_hlt;
  logic [WordW-1:0] switch_word;

  cpu_view_t   pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          quiet_phase;

  twelve_bit_accumulator_cpu_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .address_i          (address_i),
    .data_i             (data_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .read_data_o        (read_data_o),
    .program_counter_o  (program_counter_o),
    .accumulator_o      (accumulator_o),
    .link_bit_o         (link_bit_o),
    .float_accumulator_o(float_accumulator_o),
    .halted_o           (halted_o),
    .unsupported_o      (unsupported_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_twelve_bit_accumulator_cpu_unit failed");
      $finish;
    end
  end

  // Effective address with page select, indirection and auto-increment.
  task automatic resolve_address(input logic [WordW-1:0] ir, input logic [4:0] page,
                                 output logic [AddrW-1:0] ea);
    ea = {5'b0, ir[6:0]};
    if (ir[7]) ea[11:7] = page;
    if (ir[8]) begin
      if (ea[11:3] == 9'd1) mem_image[ea] = mem_image[ea] + 12'd1;
      ea = mem_image[ea];
    end
  endtask

  // The word after an floating IOT points at a word holding the operand address.
  task automatic fetch_fp_operand(output logic [AddrW-1:0] ma);
    logic [AddrW-1:0] ptr;
    ptr = mem_image[cpu_pc];
    cpu_pc = cpu_pc + 12'd1;
    ma = mem_image[ptr];
  endtask

  // Floating add: align the smaller exponent, sum signed, then normalize.
  task automatic float_add(input logic [AddrW-1:0] ma);
    logic [WordW-1:0] w1;
    logic [7:0]       ea, eb, te;
    logic             sa, sb, ts, neg;
    logic [23:0]      fa, fb, tf;
    logic [24:0]      mag;
    int               d, sum, e;
    w1 = mem_image[12'(ma + 1)];
    eb = mem_image[ma][7:0];
    sb = w1[11];
    fb = {1'b1, w1[10:0], mem_image[12'(ma + 2)]};
    ea = cpu_fac[30:23];
    sa = cpu_fac[31];
    fa = {1'b1, cpu_fac[22:0]};
    if (ea < eb) begin
      te = ea; ea = eb; eb = te;
      ts = sa; sa = sb; sb = ts;
      tf = fa; fa = fb; fb = tf;
    end
    d = int'(ea) - int'(eb);
    fb = (d >= 24) ? 24'd0 : (fb >> d);
    sum = (sa ? -int'(fa) : int'(fa)) + (sb ? -int'(fb) : int'(fb));
    neg = sum < 0;
    mag = 25'(neg ? -sum : sum);
    e = int'(ea);
    if (mag[24]) begin
      e++;
      mag = mag >> 1;
    end else if (mag != 0) begin
      while (!mag[23]) begin
        mag = mag << 1;
        e--;
      end
    end
    cpu_fac = {neg, 8'(e), mag[22:0]};
  endtask

  // Floating multiply: product of the two mantissas, one normalizing shift.
  task automatic float_mul(input logic [AddrW-1:0] ma);
    logic [WordW-1:0] w1;
    logic [23:0]      fa, fb;
    logic [47:0]      prod;
    int               e;
    w1 = mem_image[12'(ma + 1)];
    fb = {1'b1, w1[10:0], mem_image[12'(ma + 2)]};
    fa = {1'b1, cpu_fac[22:0]};
    prod = 48'(fa) * 48'(fb);
    e = int'(cpu_fac[30:23]) + int'(mem_image[ma][7:0]) - int'(EXP_BIAS);
    if (prod[47]) begin
      e++;
      prod = prod >> 1;
    end
    cpu_fac = {cpu_fac[31] ^ w1[11], 8'(e), prod[45:23]};
  endtask

  // Operate microinstructions, groups 1 and 2.
  task automatic operate(input logic [WordW-1:0] ir, inout bit unsup);
    logic        skip;
    logic [12:0] v;
    if (ir[8]) begin
      if (ir[0]) begin
        unsup = 1'b1;
        return;
      end
      if (ir[3]) begin
        skip = 1'b1;
        if (ir[4] && cpu_lnk) skip = 1'b0;
        if (ir[5] && cpu_acc == 0) skip = 1'b0;
        if (ir[6] && cpu_acc[11]) skip = 1'b0;
      end else begin
        skip = 1'b0;
        if (ir[4] && cpu_lnk) skip = 1'b1;
        if (ir[5] && cpu_acc == 0) skip = 1'b1;
        if (ir[6] && cpu_acc[11]) skip = 1'b1;
      end
      if (skip) cpu_pc = cpu_pc + 12'd1;
      if (ir[7]) cpu_acc = '0;
      if (ir[2]) cpu_acc = cpu_acc | switch_word;
      if (ir[1]) cpu_hlt = 1'b1;
    end else begin
      if (ir[7]) cpu_acc = '0;
      if (ir[6]) cpu_lnk = 1'b0;
      if (ir[5]) cpu_acc = ~cpu_acc;
      if (ir[4]) cpu_lnk = ~cpu_lnk;
      if (ir[0]) {cpu_lnk, cpu_acc} = {cpu_lnk, cpu_acc} + 13'd1;
      v = {cpu_lnk, cpu_acc};
      case (ir[3:1])
        ROT_BSW: v = {cpu_lnk, cpu_acc[5:0], cpu_acc[11:6]};
        ROT_RAL: v = {v[11:0], v[12]};
        ROT_RTL: v = {v[10:0], v[12:11]};
        ROT_RAR: v = {v[0], v[12:1]};
        ROT_RTR: v = {v[1:0], v[12:2]};
        ROT_BAD6, ROT_BAD7: unsup = 1'b1;
        default: ;
      endcase
      {cpu_lnk, cpu_acc} = v;
    end
  endtask

  // One instruction at the predicted program counter.
  task automatic execute_instruction(inout bit unsup);
    logic [WordW-1:0] ir;
    logic [4:0]       page;
    logic [AddrW-1:0] ma;
    logic [12:0]      v;
    ir = mem_image[cpu_pc];
    page = cpu_pc[11:7];
    cpu_pc = cpu_pc + 12'd1;
    case (ir[11:9])
      OP_AND: begin
        resolve_address(ir, page, ma);
        cpu_acc = cpu_acc & mem_image[ma];
      end
      OP_TAD: begin
        resolve_address(ir, page, ma);
        v = {1'b0, cpu_acc} + {1'b0, mem_image[ma]};
        if (v[12]) cpu_lnk = ~cpu_lnk;
        cpu_acc = v[11:0];
      end
      OP_ISZ: begin
        resolve_address(ir, page, ma);
        mem_image[ma] = mem_image[ma] + 12'd1;
        if (mem_image[ma] == 0) cpu_pc = cpu_pc + 12'd1;
      end
      OP_DCA: begin
        resolve_address(ir, page, ma);
        mem_image[ma] = cpu_acc;
        cpu_acc = '0;
      end
      OP_JMS: begin
        resolve_address(ir, page, ma);
        mem_image[ma] = cpu_pc;
        cpu_pc = ma + 12'd1;
      end
      OP_JMP: begin
        resolve_address(ir, page, ma);
        cpu_pc = ma;
      end
      OP_IOT: begin
        if (ir == IOT_FCLR) begin
          cpu_fac = '0;
        end else if (ir == IOT_FLD) begin
          fetch_fp_operand(ma);
          cpu_fac = {mem_image[12'(ma + 1)][11], mem_image[ma][7:0],
                     mem_image[12'(ma + 1)][10:0], mem_image[12'(ma + 2)]};
        end else if (ir == IOT_FST) begin
          fetch_fp_operand(ma);
          mem_image[ma] = {4'b0, cpu_fac[30:23]};
          mem_image[12'(ma + 1)] = {cpu_fac[31], cpu_fac[22:12]};
          mem_image[12'(ma + 2)] = cpu_fac[11:0];
        end else if (ir == IOT_FADD) begin
          fetch_fp_operand(ma);
          float_add(ma);
        end else if (ir == IOT_FMUL) begin
          fetch_fp_operand(ma);
          float_mul(ma);
        end else begin
          unsup = 1'b1;
        end
      end
      default: operate(ir, unsup);
    endcase
  endtask

  // Apply one accepted request to the predicted state and queue its result.
  task automatic predict_request(input logic [1:0] cmd, input logic [AddrW-1:0] addr,
                                 input logic [WordW-1:0] data);
    cpu_view_t r;
    bit        unsup;
    unsup = 1'b0;
    r.rdata = '0;
    case (cmd)
      CMD_WRITE: mem_image[addr] = data;
      CMD_READ:  r.rdata = mem_image[addr];
      CMD_EXEC:  if (!cpu_hlt) execute_instruction(unsup);
      default: begin
        cpu_pc = addr;
        cpu_hlt = 1'b0;
      end
    endcase
    r.pc = cpu_pc;
    r.acc = cpu_acc;
    r.lnk = cpu_lnk;
    r.fac = cpu_fac;
    r.hlt = cpu_hlt;
    r.unsup = unsup;
    pending_results.push_back(r);
  endtask

  // Drive one request and hold it until the block takes it.
  task automatic send_request(input logic [1:0] cmd, input logic [AddrW-1:0] addr,
                              input logic [WordW-1:0] data);
    int unsigned gap;
    @(negedge clk_i);
    cmd_i = cmd;
    address_i = addr;
    data_i = data;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_request(cmd, addr, data);
    // Random idle time after the request, none in quiet phases.
    gap = $urandom_range(0, 99);
    if (!quiet_phase && gap >= 55) begin
      gap = (gap >= 92) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Write the switch register once every pending result has arrived.
  task automatic set_switches(input logic [WordW-1:0] value);
    wait (pending_results.size() == 0);
    @(negedge clk_i);
    start = 1'b0;
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    switch_word = value;
  endtask

  // Place an instruction at the program counter and run it.
  task automatic plant_and_run(input logic [WordW-1:0] ir);
    send_request(CMD_WRITE, cpu_pc, ir);
    send_request(CMD_EXEC, 12'($urandom()), 12'($urandom()));
  endtask

  // Give every memory word a defined value before anything reads it.
  task automatic test_fill_memory();
    quiet_phase = 1'b1;
    for (int a = 0; a < MemWords; a++) send_request(CMD_WRITE, 12'(a), 12'($urandom()));
    quiet_phase = 1'b0;
  endtask

  // Field extremes, each operation group and the special cases.
  task automatic test_directed();
    send_request(CMD_WRITE, 12'hFFF, 12'hFFF);
    send_request(CMD_READ, 12'hFFF, 12'h000);
    send_request(CMD_WRITE, 12'h000, 12'h000);
    send_request(CMD_READ, 12'h000, 12'hFFF);
    // Program counter wrap from the top of memory.
    send_request(CMD_START, 12'hFFF, 12'h000);
    plant_and_run(12'o7001);
    // Carry out of IAC and TAD into the link.
    plant_and_run(12'o7261);
    plant_and_run(12'o1410);
    plant_and_run(12'o2017);
    plant_and_run(12'o7014);
    plant_and_run(12'o7016);
    plant_and_run(12'o7002);
    plant_and_run(12'o7012);
    plant_and_run(12'o7015);
    plant_and_run(12'o7450);
    plant_and_run(12'o7604);
    plant_and_run(IOT_FADD);
    plant_and_run(IOT_FMUL);
    plant_and_run(12'o6001);
    // Halt, then an execute that must change nothing.
    plant_and_run(12'o7402);
    send_request(CMD_EXEC, 12'h000, 12'h000);
    send_request(CMD_START, 12'o0200, 12'h000);
  endtask

  // Mostly planted instructions of every kind, with plain traffic mixed in.
  task automatic test_random(input int unsigned count);
    int unsigned k;
    logic [WordW-1:0] ir;
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (cpu_hlt && k < 60) begin
        send_request(CMD_START, 12'($urandom()), 12'($urandom()));
      end else if (k < 8) begin
        send_request(CMD_READ, 12'($urandom()), 12'($urandom()));
      end else if (k < 14) begin
        send_request(CMD_WRITE, 12'($urandom()), 12'($urandom()));
      end else if (k < 18) begin
        send_request(CMD_START, 12'($urandom()), 12'($urandom()));
      end else if (k < 30) begin
        send_request(CMD_EXEC, 12'($urandom()), 12'($urandom()));
      end else begin
        k = $urandom_range(0, 99);
        if (k < 35) ir = {3'($urandom_range(0, 5)), 9'($urandom())};
        else if (k < 70) ir = {3'b111, 9'($urandom())};
        else if (k < 92) ir = IOT_FCLR + 12'($urandom_range(0, 4));
        else ir = {3'b110, 9'($urandom())};
        plant_and_run(ir);
      end
    end
  endtask

  // Compare every result with the oldest prediction.
  always @(posedge clk_i) begin
    cpu_view_t seen, want;
    if (rst_ni && done_o) begin
      seen = '{read_data_o, program_counter_o, accumulator_o, link_bit_o,
               float_accumulator_o, halted_o, unsupported_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected result: %p", seen);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("mismatch: expected %p actual %p", want, seen);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    start = 1'b0;
    cmd_i = CMD_WRITE;
    address_i = '0;
    data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    quiet_phase = 1'b0;
    cpu_pc = PC_RESET;
    cpu_acc = '0;
    cpu_lnk = 1'b0;
    cpu_fac = '0;
    cpu_hlt = 1'b0;
    switch_word = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_memory();
    set_switches(12'hFFF);
    test_directed();
    set_switches(12'h000);
    test_directed();
    set_switches(12'($urandom()));
    test_random(250);
    set_switches(12'hFFF);
    quiet_phase = 1'b1;
    test_random(200);
    quiet_phase = 1'b0;
    set_switches(12'($urandom()));
    test_random(300);
    set_switches(12'h000);
    test_random(300);

    @(negedge clk_i);
    start = 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_twelve_bit_accumulator_cpu_unit passed");
    end else begin
      $display("tb_twelve_bit_accumulator_cpu_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/tbac_pkg.sv
rtl/tbac_dp.sv
rtl/tbac_ctrl.sv
rtl/twelve_bit_accumulator_cpu_unit.sv
tb/sv/tb_twelve_bit_accumulator_cpu_unit.sv
